// ===== hw/rtl/lbp_pkg.sv =====
// Package for the LSB-first bit packer: constants, operation codes and the
// byte-run job record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package lbp_pkg;

	localparam int unsigned MaxFieldBits = 32;
	localparam int unsigned ByteBits     = 8;
	localparam int unsigned PendBits     = 7;
	localparam int unsigned FillBits     = 3;
	localparam int unsigned WidthBits    = 6;
	localparam int unsigned JobBytes     = 4;
	localparam int unsigned CountBits    = 3;
	localparam int unsigned AccBits      = PendBits + MaxFieldBits;
	localparam int unsigned IdxBits      = 2;
	localparam int unsigned QDepth       = 4;
	localparam int unsigned QAw          = 2;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_ALIGN  = 1'b1
	} op_t;

	// A run of one to four completed bytes, first byte in the low bits.
	typedef struct packed {
		logic [JobBytes*ByteBits-1:0] bytes;
		logic [CountBits-1:0]         count;
	} job_t;

endpackage

// ===== hw/rtl/lbp_front.sv =====
// Front end of the bit packer: accepts items, keeps the partial byte and
// its fill count, and queues each run of completed bytes. Depends on lbp_pkg.
`timescale 1ns / 1ps

module lbp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              op,
	input  logic [lbp_pkg::MaxFieldBits-1:0]  field_value,
	input  logic [lbp_pkg::WidthBits-1:0]     field_width,
	output logic                              q_push,
	output lbp_pkg::job_t                     q_din,
	input  logic                              q_full
);

	logic [lbp_pkg::PendBits-1:0]     pending_q;
	logic [lbp_pkg::FillBits-1:0]     fill_q;
	logic [lbp_pkg::MaxFieldBits:0]   mask;
	logic [lbp_pkg::MaxFieldBits-1:0] masked;
	logic [lbp_pkg::AccBits-1:0]      acc;
	logic [lbp_pkg::AccBits-1:0]      rest;
	logic [lbp_pkg::WidthBits-1:0]    total;
	logic [lbp_pkg::CountBits-1:0]    nbytes;
	logic                             accept;
	logic                             upd;
	logic [lbp_pkg::PendBits-1:0]     pending_d;
	logic [lbp_pkg::FillBits-1:0]     fill_d;

	assign full   = q_full;
	assign accept = push && !q_full;

	assign mask   = ({{lbp_pkg::MaxFieldBits{1'b0}}, 1'b1} << field_width)
		- {{lbp_pkg::MaxFieldBits{1'b0}}, 1'b1};
	assign masked = field_value & mask[lbp_pkg::MaxFieldBits-1:0];
	assign acc    = {{lbp_pkg::MaxFieldBits{1'b0}}, pending_q}
		| ({{lbp_pkg::PendBits{1'b0}}, masked} << fill_q);
	assign total  = {{(lbp_pkg::WidthBits-lbp_pkg::FillBits){1'b0}}, fill_q} + field_width;
	assign nbytes = total[lbp_pkg::WidthBits-1:lbp_pkg::FillBits];
	assign rest   = acc >> {nbytes, 3'b000};

	always_comb begin
		q_push    = 1'b0;
		q_din     = '0;
		upd       = 1'b0;
		pending_d = pending_q;
		fill_d    = fill_q;
		unique case (lbp_pkg::op_t'(op))
			lbp_pkg::OP_ALIGN: begin
				q_din.bytes = {{(lbp_pkg::JobBytes*lbp_pkg::ByteBits-lbp_pkg::PendBits){1'b0}},
					pending_q};
				q_din.count = lbp_pkg::CountBits'(1);
				q_push      = accept && (fill_q != '0);
				upd         = accept;
				pending_d   = '0;
				fill_d      = '0;
			end
			lbp_pkg::OP_APPEND: begin
				q_din.bytes = acc[lbp_pkg::JobBytes*lbp_pkg::ByteBits-1:0];
				q_din.count = nbytes;
				// Widths above the maximum leave everything untouched.
				upd         = accept && (field_width <= lbp_pkg::WidthBits'(lbp_pkg::MaxFieldBits));
				q_push      = upd && (nbytes != '0);
				pending_d   = rest[lbp_pkg::PendBits-1:0];
				fill_d      = total[lbp_pkg::FillBits-1:0];
			end
			default: begin
				upd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			fill_q    <= '0;
		end else if (upd) begin
			pending_q <= pending_d;
			fill_q    <= fill_d;
		end
	end

endmodule

// ===== hw/rtl/lbp_queue.sv =====
// Short first-in first-out queue of byte-run jobs between the front and
// back ends of the bit packer. Depends on lbp_pkg.
`timescale 1ns / 1ps

module lbp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_push,
	input  lbp_pkg::job_t q_din,
	output logic          q_full,
	input  logic          q_pop,
	output lbp_pkg::job_t q_dout,
	output logic          q_empty
);

	lbp_pkg::job_t              mem_q [lbp_pkg::QDepth];
	logic [lbp_pkg::QAw-1:0]    wr_ptr_q;
	logic [lbp_pkg::QAw-1:0]    rd_ptr_q;
	logic [lbp_pkg::QAw:0]      cnt_q;

	assign q_full  = (cnt_q == (lbp_pkg::QAw+1)'(lbp_pkg::QDepth));
	assign q_empty = (cnt_q == '0);
	assign q_dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push && !q_full) begin
			mem_q[wr_ptr_q] <= q_din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_push && !q_full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop && !q_empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + {{lbp_pkg::QAw{1'b0}}, (q_push && !q_full)}
				- {{lbp_pkg::QAw{1'b0}}, (q_pop && !q_empty)};
		end
	end

endmodule

// ===== hw/rtl/lbp_back.sv =====
// Back end of the bit packer: takes byte-run jobs from the queue and hands
// out one byte per transfer. Depends on lbp_pkg.
`timescale 1ns / 1ps

module lbp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  lbp_pkg::job_t                q_dout,
	output logic                         empty,
	input  logic                         pop,
	output logic [lbp_pkg::ByteBits-1:0] data_byte,
	output logic                         last_of_run
);

	lbp_pkg::job_t               job_q;
	logic                        valid_q;
	logic [lbp_pkg::IdxBits-1:0] idx_q;
	logic                        take;

	assign empty       = !valid_q;
	assign data_byte   = job_q.bytes[{idx_q, 3'b000} +: lbp_pkg::ByteBits];
	assign last_of_run = ({1'b0, idx_q} + 1'b1) == job_q.count;
	assign take        = !valid_q || (pop && last_of_run);
	assign q_pop       = take && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_dout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= !q_empty;
			idx_q   <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// ===== hw/rtl/lsb_first_bit_packer.sv =====
// LSB-first bit packer, top level. An item's completed bytes are written
// into the queue at its transfer in, and the job loads into the output stage
// when the back end takes its next job from the queue.
// Throughput: one item per cycle in while the queue is not full; one byte per
// cycle out while the receiver pops, and an item completes zero to four bytes.
// Reset: arst_n clears the partial byte, fill count, queue and output stage.
`timescale 1ns / 1ps

module lsb_first_bit_packer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              op,
	input  logic [lbp_pkg::MaxFieldBits-1:0]  field_value,
	input  logic [lbp_pkg::WidthBits-1:0]     field_width,
	output logic                              empty,
	input  logic                              pop,
	output logic [lbp_pkg::ByteBits-1:0]      data_byte,
	output logic                              last_of_run
);

	// The front end does all bit arithmetic at the input transfer and keeps
	// the pending partial byte, so the next item can follow at once. Each
	// item that completes bytes becomes one job in a four-entry queue. The
	// output rate is set by the back end, which sends one byte per transfer.

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	lbp_pkg::job_t q_din;
	lbp_pkg::job_t q_dout;

	lbp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.field_value (field_value),
		.field_width (field_width),
		.q_push      (q_push),
		.q_din       (q_din),
		.q_full      (q_full)
	);

	lbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_din   (q_din),
		.q_full  (q_full),
		.q_pop   (q_pop),
		.q_dout  (q_dout),
		.q_empty (q_empty)
	);

	lbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_dout      (q_dout),
		.empty       (empty),
		.pop         (pop),
		.data_byte   (data_byte),
		.last_of_run (last_of_run)
	);

	// A job entering the queue always carries one to four bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_din.count != '0 && q_din.count <= 3'd4))
		else $error("job with bad byte count queued");

	// A run that is not finished keeps the output side busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_run) |=> !empty)
		else $error("byte run cut short");

	// The back end only takes jobs that exist.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("read from empty job queue");

	// A full queue cannot also be empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_empty)
		else $error("queue status inconsistent");

endmodule

// ===== dv/lsb_first_bit_packer_checker.sv =====
// Checker for the LSB-first bit packer: watches both queue-style channels,
// predicts the byte stream and compares every popped byte with it.
// Depends on lbp_pkg for widths and operation codes.
`timescale 1ns / 1ps

module lsb_first_bit_packer_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic                              op,
	input  logic [lbp_pkg::MaxFieldBits-1:0]  field_value,
	input  logic [lbp_pkg::WidthBits-1:0]     field_width,
	input  logic                              empty,
	input  logic                              pop,
	input  logic [lbp_pkg::ByteBits-1:0]      data_byte,
	input  logic                              last_of_run,
	output int                                errors,
	output int                                bytes_owed
);

	import lbp_pkg::*;

	typedef struct packed {
		logic [ByteBits-1:0] data;
		logic                last;
	} out_byte_t;

	out_byte_t              bytes_due[$];
	logic [PendBits-1:0]    held_bits;
	logic [FillBits-1:0]    held_fill;
	int                     mismatch_count = 0;

	assign errors     = mismatch_count;
	assign bytes_owed = bytes_due.size();

	// Appends a field (or flushes the partial byte) and queues the bytes it completes.
	function automatic void pack_field(input op_t kind, input logic [MaxFieldBits-1:0] value,
			input logic [WidthBits-1:0] width);
		logic [AccBits-1:0] acc;
		int unsigned        total;
		int unsigned        nbytes;
		int unsigned        k;
		out_byte_t          entry;
		if (kind == OP_ALIGN) begin
			if (held_fill != 0) begin
				entry.data = {1'b0, held_bits};
				entry.last = 1'b1;
				bytes_due.insert(bytes_due.size(), entry);
				held_bits = '0;
				held_fill = '0;
			end
		end else if (width != 0 && width <= MaxFieldBits) begin
			acc = (AccBits'(value) & ((AccBits'(1) << width) - 1)) << held_fill;
			acc = acc | AccBits'(held_bits);
			total = held_fill + width;
			nbytes = total / ByteBits;
			for (k = 0; k < nbytes; k++) begin
				entry.data = acc[k*ByteBits +: ByteBits];
				entry.last = (k + 1 == nbytes);
				bytes_due.insert(bytes_due.size(), entry);
			end
			held_fill = FillBits'(total % ByteBits);
			held_bits = PendBits'(acc >> (nbytes * ByteBits));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_byte_t want;
		if (!arst_n) begin
			held_bits = '0;
			held_fill = '0;
			bytes_due.delete();
		end else begin
			if (pop && !empty) begin
				if (bytes_due.size() == 0) begin
					$display("%0t: unexpected byte: actual data_byte=%h last_of_run=%b",
						$time, data_byte, last_of_run);
					mismatch_count++;
				end else begin
					want = bytes_due.pop_front();
					if (data_byte !== want.data) begin
						$display("%0t: data_byte mismatch: expected %h, actual %h",
							$time, want.data, data_byte);
						mismatch_count++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run mismatch: expected %b, actual %b",
							$time, want.last, last_of_run);
						mismatch_count++;
					end
				end
			end
			if (push && !full)
				pack_field(op_t'(op), field_value, field_width);
		end
	end

endmodule

// ===== dv/lsb_first_bit_packer_tb.sv =====
// Testbench top for the LSB-first bit packer: clock, reset, stimulus, random
// idling on both sides, a watchdog and the verdict.
// Depends on lbp_pkg, lsb_first_bit_packer and lsb_first_bit_packer_checker.
`timescale 1ns / 1ps

module lsb_first_bit_packer_tb;

	import lbp_pkg::*;

	// The run is declared hung once this many cycles pass without any transfer
	// on either side. The longest legal quiet stretch is the receiver hold below.
	localparam int unsigned StallLimit  = 4000;
	localparam int unsigned HoldCycles  = 200;
	localparam int unsigned DrainCycles = 20;
	localparam int unsigned RandomItems = 300;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     push        = 1'b0;
	logic                     full;
	logic                     op          = 1'b0;
	logic [MaxFieldBits-1:0]  field_value = '0;
	logic [WidthBits-1:0]     field_width = '0;
	logic                     empty;
	logic                     pop         = 1'b0;
	logic [ByteBits-1:0]      data_byte;
	logic                     last_of_run;

	int                       errors;
	int                       bytes_owed;
	int unsigned              quiet_cycles = 0;

	// Set by the sender to ask the receiver for one long hold-off; the receiver
	// clears it once the hold starts. no_idle turns off gaps on both sides.
	bit                       hold_request = 1'b0;
	bit                       no_idle      = 1'b0;

	always #1 clk = ~clk;

	lsb_first_bit_packer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.field_value (field_value),
		.field_width (field_width),
		.empty       (empty),
		.pop         (pop),
		.data_byte   (data_byte),
		.last_of_run (last_of_run)
	);

	lsb_first_bit_packer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.field_value (field_value),
		.field_width (field_width),
		.empty       (empty),
		.pop         (pop),
		.data_byte   (data_byte),
		.last_of_run (last_of_run),
		.errors      (errors),
		.bytes_owed  (bytes_owed)
	);

	// Gap lengths: most are zero or short, a few are long. Gaps vanish while
	// no_idle is set so that some stretches run at full rate.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		else if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Field widths lean toward the short ones, with regular full 32-bit fields
	// and the occasional zero width or out-of-range width that must be ignored.
	function automatic logic [WidthBits-1:0] pick_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		else if (r < 6)
			return WidthBits'($urandom_range(MaxFieldBits + 1, 63));
		else if (r < 20)
			return WidthBits'(MaxFieldBits);
		else if (r < 30)
			return WidthBits'($urandom_range(24, 31));
		else
			return WidthBits'($urandom_range(1, 16));
	endfunction

	// Offers one item at a falling edge and holds it until the block takes it.
	// After the transfer, push drops for the requested number of cycles; with
	// no gap the next call keeps push high without lowering it in between.
	task automatic send_item(input op_t kind, input logic [MaxFieldBits-1:0] value,
			input logic [WidthBits-1:0] width, input int unsigned gap);
		@(negedge clk);
		push        <= 1'b1;
		op          <= kind;
		field_value <= value;
		field_width <= width;
		do
			@(posedge clk);
		while (full);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Receiver: pops with random gaps and, once asked, holds off for a long
	// stretch so that the block fills up and pushes back on the sender.
	initial begin
		int unsigned rx_gap;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (HoldCycles - 1) @(negedge clk);
			end else if (rx_gap > 0) begin
				pop <= 1'b0;
				rx_gap--;
			end else begin
				pop <= 1'b1;
				rx_gap = pick_gap();
			end
		end
	end

	// Watchdog: any transfer on either side resets the count.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned counted;
		int unsigned r;
		op_t         kind;
		logic [WidthBits-1:0] width;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Align on an empty partial byte, then zero width.
		send_item(OP_ALIGN,  32'hFFFF_FFFF, 6'd63, 0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd0,  0);
		// Fill the partial byte to seven bits, then a full field on top of it
		// completes four bytes at once and leaves seven bits behind.
		send_item(OP_APPEND, 32'h0000_0001, 6'd1,  0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd6,  0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd32, 1);
		// Widths above 32 must leave the state untouched.
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd33, 0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd63, 0);
		// Flush the seven leftover bits, then align again with nothing pending.
		send_item(OP_ALIGN,  32'h0000_0000, 6'd0,  0);
		send_item(OP_ALIGN,  32'hFFFF_FFFF, 6'd32, 2);
		// Byte-aligned full-width fields of all zeros and a mixed pattern, then a byte.
		send_item(OP_APPEND, 32'h0000_0000, 6'd32, 0);
		send_item(OP_APPEND, 32'hA5A5_5A5A, 6'd32, 0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd8,  0);
		// Stray bits above the width must be dropped.
		send_item(OP_APPEND, 32'hFFFF_FFF5, 6'd3,  0);
		send_item(OP_ALIGN,  32'h0000_00FF, 6'd63, 0);
		send_item(OP_APPEND, 32'h0000_007F, 6'd7,  0);
		send_item(OP_APPEND, 32'hFFFF_FFFF, 6'd1,  3);
		send_item(OP_APPEND, 32'h1234_FFFF, 6'd16, 0);
		send_item(OP_APPEND, 32'h8000_0000, 6'd5,  0);
		send_item(OP_ALIGN,  32'h0000_0000, 6'd0,  4);

		// Back-pressure burst: the receiver stops for a long stretch while the
		// sender keeps offering full-width fields without any gap.
		hold_request = 1'b1;
		repeat (30)
			send_item(OP_APPEND, $urandom, 6'd32, 0);

		// Random part, in phases of varying idling.
		counted = 0;
		while (counted < RandomItems) begin
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (40) begin
				r = $urandom_range(0, 99);
				kind = (r < 10) ? OP_ALIGN : OP_APPEND;
				width = pick_width();
				counted++;
				send_item(kind, $urandom, width, pick_gap());
			end
		end
		no_idle = 1'b0;

		// Close with an align so the last partial byte comes out too.
		send_item(OP_ALIGN, $urandom, pick_width(), 0);
		@(negedge clk);
		push <= 1'b0;

		// Wait for every predicted byte, then give the block time to show any
		// extra output before the verdict.
		wait (bytes_owed == 0);
		repeat (DrainCycles) @(posedge clk);

		if (errors == 0 && bytes_owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
